[rtl/core/sbsm_pkg.sv]
// Shared types, codes and constants for the serial bank switch mapper.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps
`default_nettype none

package sbsm_pkg;

    // Serial loader: five beats, LSB first
    localparam int SERIAL_WRITES = 5;
    localparam int SHIFT_CNT_W   = $clog2(SERIAL_WRITES + 1);
    localparam int MAP_REG_W     = SERIAL_WRITES;

    localparam logic [MAP_REG_W-1:0] CONTROL_RESET = 5'h0C;
    localparam logic [MAP_REG_W-1:0] PRG_MODE_MASK = 5'h0C;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic CFG_IDX_CHR_ROM   = 1'b0;
    localparam logic CFG_IDX_PRG_BANKS = 1'b1;
    localparam logic [4:0] PRG_BANKS_RESET = 5'd16;
    localparam logic [4:0] PRG_BANKS_MAX   = 5'd16;

    // Mapper register select, address bits 14:13
    localparam logic [1:0] SEL_CONTROL  = 2'd0;
    localparam logic [1:0] SEL_CHR_LOW  = 2'd1;
    localparam logic [1:0] SEL_CHR_HIGH = 2'd2;
    localparam logic [1:0] SEL_PRG_BANK = 2'd3;

    // PRG banking modes, control bits 3:2
    localparam logic [1:0] PRG_MODE_SWITCH_HI = 2'd2;
    localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;

    // Bus region, address bits 15:13
    localparam logic [2:0] REGION_IRAM    = 3'b000;
    localparam logic [2:0] REGION_CHR     = 3'b001;
    localparam logic [2:0] REGION_UNMAP   = 3'b010;
    localparam logic [2:0] REGION_PRG_RAM = 3'b011;

    typedef enum logic [2:0] {
        TGT_NONE    = 3'd0,
        TGT_IRAM    = 3'd1,
        TGT_CHR_RAM = 3'd2,
        TGT_CHR_ROM = 3'd3,
        TGT_PRG_RAM = 3'd4,
        TGT_PRG_ROM = 3'd5
    } tgt_t;

    typedef struct packed {
        logic        req_type;
        logic [15:0] address;
        logic [7:0]  write_data;
    } in_beat_t;

    typedef struct packed {
        tgt_t        target;
        logic [17:0] offset;
        logic        write_enable;
        logic [7:0]  out_data;
    } out_beat_t;

    typedef struct packed {
        logic       chr_rom_present;
        logic [4:0] prg_rom_banks;
    } cfg_t;

    typedef struct packed {
        logic [MAP_REG_W-1:0] control;
        logic [MAP_REG_W-1:0] chr_low;
        logic [MAP_REG_W-1:0] chr_high;
        logic [MAP_REG_W-1:0] prg_bank;
    } map_state_t;

    // One beat's request to the serial loader
    typedef struct packed {
        logic       wr;
        logic       clr;
        logic       data_bit;
        logic [1:0] sel;
    } map_req_t;

endpackage

`default_nettype wire

[rtl/core/sbsm_cfg_regs.sv]
// APB-style configuration registers: CHR ROM fitted flag and PRG bank count.
// Depends on sbsm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbsm_cfg_regs (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire [sbsm_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire [sbsm_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [sbsm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output sbsm_pkg::cfg_t                 cfg
);
    import sbsm_pkg::*;

    logic       chr_rom_reg;
    logic       chr_rom_next;
    logic [4:0] banks_reg;
    logic [4:0] banks_next;
    logic       wr_en;
    logic       idx;

    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[2];
    assign pready = 1'b1;

    always_comb
    begin
        chr_rom_next = chr_rom_reg;
        banks_next   = banks_reg;
        if (wr_en)
        begin
            unique case (idx)
                CFG_IDX_CHR_ROM:   chr_rom_next = pwdata[0];
                CFG_IDX_PRG_BANKS: banks_next   = pwdata[4:0];
                default:           chr_rom_next = chr_rom_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            CFG_IDX_CHR_ROM:   prdata = {{(CFG_DATA_W-1){1'b0}}, chr_rom_reg};
            CFG_IDX_PRG_BANKS: prdata = {{(CFG_DATA_W-5){1'b0}}, banks_reg};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chr_rom_reg <= 1'b0;
            banks_reg   <= PRG_BANKS_RESET;
        end
        else
        begin
            chr_rom_reg <= chr_rom_next;
            banks_reg   <= banks_next;
        end
    end

    assign cfg.chr_rom_present = chr_rom_reg;
    assign cfg.prg_rom_banks   = banks_reg;

endmodule

`default_nettype wire

[rtl/core/sbsm_decode.sv]
// Address decode and bank mapping for one bus beat; also forms the loader request.
// Depends on sbsm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbsm_decode (
    input  sbsm_pkg::in_beat_t   beat,
    input  sbsm_pkg::map_state_t state,
    input  sbsm_pkg::cfg_t       cfg,
    output sbsm_pkg::out_beat_t  result,
    output sbsm_pkg::map_req_t   req
);
    import sbsm_pkg::*;

    logic        wr;
    logic [15:0] a;
    logic [3:0]  bank;
    logic [3:0]  last_bank;
    logic [4:0]  banks_clamped;
    logic [1:0]  prg_mode;
    logic [17:0] chr_off;
    logic [17:0] prg_off;
    logic        ram_on;

    assign wr       = beat.req_type;
    assign a        = beat.address;
    assign bank     = state.prg_bank[3:0];
    assign prg_mode = state.control[3:2];
    assign ram_on   = !state.prg_bank[4];

    // Bank count clamped to 1..16, last bank fixed at the top
    always_comb
    begin
        priority if (cfg.prg_rom_banks == 5'd0)
            banks_clamped = 5'd1;
        else if (cfg.prg_rom_banks > PRG_BANKS_MAX)
            banks_clamped = PRG_BANKS_MAX;
        else
            banks_clamped = cfg.prg_rom_banks;
    end
    assign last_bank = 4'(banks_clamped - 5'd1);

    // CHR: one 8 KiB bank (low bit ignored) or two 4 KiB banks
    always_comb
    begin
        priority if (!state.control[4])
            chr_off = {1'b0, state.chr_low[4:1], a[12:0]};
        else if (a[12])
            chr_off = {1'b0, state.chr_high, a[11:0]};
        else
            chr_off = {1'b0, state.chr_low, a[11:0]};
    end

    // PRG: 32 KiB switch, or 16 KiB with one half fixed
    always_comb
    begin
        priority if (prg_mode == PRG_MODE_SWITCH_HI)
            prg_off = a[14] ? {bank, a[13:0]} : {4'd0, a[13:0]};
        else if (prg_mode == PRG_MODE_FIX_LAST)
            prg_off = a[14] ? {last_bank, a[13:0]} : {bank, a[13:0]};
        else
            prg_off = {bank[3:1], a[14:0]};
    end

    always_comb
    begin
        result.target       = TGT_NONE;
        result.offset       = '0;
        result.write_enable = 1'b0;
        req.wr              = 1'b0;
        req.clr             = beat.write_data[7];
        req.data_bit        = beat.write_data[0];
        req.sel             = a[14:13];
        priority if (a[15])
        begin
            if (wr)
                req.wr = 1'b1;
            else
            begin
                result.target = TGT_PRG_ROM;
                result.offset = prg_off;
            end
        end
        else if (a[15:13] == REGION_IRAM)
        begin
            result.target       = TGT_IRAM;
            result.offset       = {7'd0, a[10:0]};
            result.write_enable = wr;
        end
        else if (a[15:13] == REGION_CHR)
        begin
            if (!cfg.chr_rom_present)
            begin
                result.target       = TGT_CHR_RAM;
                result.offset       = {5'd0, a[12:0]};
                result.write_enable = wr;
            end
            else if (!wr)
            begin
                result.target = TGT_CHR_ROM;
                result.offset = chr_off;
            end
        end
        else if (a[15:13] == REGION_PRG_RAM)
        begin
            if (ram_on)
            begin
                result.target       = TGT_PRG_RAM;
                result.offset       = {5'd0, a[12:0]};
                result.write_enable = wr;
            end
        end
        else
        begin
            // unmapped window: nothing
            result.target = TGT_NONE;
        end
        result.out_data = result.write_enable ? beat.write_data : 8'd0;
    end

endmodule

`default_nettype wire

[rtl/core/sbsm_map_regs.sv]
// Serial loader and the four mapper registers it commits into.
// Depends on sbsm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbsm_map_regs (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  update,
    input  sbsm_pkg::map_req_t   req,
    output sbsm_pkg::map_state_t state
);
    import sbsm_pkg::*;

    logic [MAP_REG_W-1:0]   bits_reg;
    logic [MAP_REG_W-1:0]   bits_next;
    logic [SHIFT_CNT_W-1:0] cnt_reg;
    logic [SHIFT_CNT_W-1:0] cnt_next;
    map_state_t             map_reg;
    map_state_t             map_next;
    logic [MAP_REG_W-1:0]   bits_tmp;
    logic [SHIFT_CNT_W-1:0] cnt_tmp;

    always_comb
    begin
        bits_next = bits_reg;
        cnt_next  = cnt_reg;
        map_next  = map_reg;
        // count never rests at the full width, but stay safe if it did
        cnt_tmp   = (cnt_reg >= SHIFT_CNT_W'(SERIAL_WRITES)) ? '0 : cnt_reg;
        bits_tmp  = (cnt_reg >= SHIFT_CNT_W'(SERIAL_WRITES)) ? '0 : bits_reg;
        bits_tmp  = bits_tmp | (MAP_REG_W'(req.data_bit) << cnt_tmp);
        if (update && req.wr)
        begin
            if (req.clr)
            begin
                map_next.control = map_reg.control | PRG_MODE_MASK;
                bits_next        = '0;
                cnt_next         = '0;
            end
            else if (cnt_tmp == SHIFT_CNT_W'(SERIAL_WRITES - 1))
            begin
                unique case (req.sel)
                    SEL_CONTROL:  map_next.control  = bits_tmp;
                    SEL_CHR_LOW:  map_next.chr_low  = bits_tmp;
                    SEL_CHR_HIGH: map_next.chr_high = bits_tmp;
                    SEL_PRG_BANK: map_next.prg_bank = bits_tmp;
                    default:      map_next          = map_reg;
                endcase
                bits_next = '0;
                cnt_next  = '0;
            end
            else
            begin
                bits_next = bits_tmp;
                cnt_next  = cnt_tmp + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg         <= '0;
            cnt_reg          <= '0;
            map_reg.control  <= CONTROL_RESET;
            map_reg.chr_low  <= '0;
            map_reg.chr_high <= '0;
            map_reg.prg_bank <= '0;
        end
        else
        begin
            bits_reg <= bits_next;
            cnt_reg  <= cnt_next;
            map_reg  <= map_next;
        end
    end

    assign state = map_reg;

endmodule

`default_nettype wire

[rtl/core/serial_bank_switch_mapper.sv]
// Top level of the serial bank switch mapper: input register, decode, result register.
// Depends on sbsm_pkg, sbsm_cfg_regs, sbsm_decode and sbsm_map_regs.
`timescale 1ns / 1ps
`default_nettype none

// Each input beat is one processor bus access; each gives exactly one result beat
// naming the target memory, the byte offset in it and whether the byte is stored.
// Throughput is one beat per clock while out_stall is low; a beat passes the input
// register, then decode into the result register. Mapper register updates from serial
// writes land as the beat leaves the input register, so the next beat already decodes
// against them. A full result register that is stalled holds the input register, and
// in_stall rises only when both stages are full. The user must write configuration
// (CHR ROM flag at 0x0, PRG bank count at 0x4) only while idle; it is not enforced.
module serial_bank_switch_mapper (
    input  wire                             clk,
    input  wire                             rst_n,
    // bus access beats in
    input  wire                             in_valid,
    output logic                            in_stall,
    input  sbsm_pkg::in_beat_t              in_item,
    // decoded beats out
    output logic                            out_valid,
    input  wire                             out_stall,
    output sbsm_pkg::out_beat_t             out_item,
    // configuration
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire [sbsm_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire [sbsm_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [sbsm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import sbsm_pkg::*;

    // Input register
    logic       in_vld_reg;
    logic       in_vld_next;
    in_beat_t   in_item_reg;
    // Result register
    logic       res_vld_reg;
    logic       res_vld_next;
    out_beat_t  res_item_reg;

    logic       accept;
    logic       advance;
    cfg_t       cfg;
    map_state_t map_state;
    map_req_t   map_req;
    out_beat_t  decoded;

    // Beat moves on when the result slot is empty or being drained
    assign advance  = in_vld_reg && (!res_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        priority if (accept)
            in_vld_next = 1'b1;
        else if (advance)
            in_vld_next = 1'b0;
        else
            in_vld_next = in_vld_reg;

        priority if (advance)
            res_vld_next = 1'b1;
        else if (res_vld_reg && !out_stall)
            res_vld_next = 1'b0;
        else
            res_vld_next = res_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            res_vld_reg <= res_vld_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= in_item;
        if (advance)
            res_item_reg <= decoded;
    end

    sbsm_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sbsm_decode u_dec (
        .beat   (in_item_reg),
        .state  (map_state),
        .cfg    (cfg),
        .result (decoded),
        .req    (map_req)
    );

    // Loader advances only with the beat that carries the write
    sbsm_map_regs u_map (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (advance),
        .req    (map_req),
        .state  (map_state)
    );

    assign out_valid = res_vld_reg;
    assign out_item  = res_item_reg;

endmodule

`default_nettype wire

[rtl/core/sbsm_checker.sv]
// Port-level checks for serial_bank_switch_mapper, attached by bind.
// Depends on sbsm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbsm_checker (
    input wire                 clk,
    input wire                 rst_n,
    input wire                 out_valid,
    input wire                 out_stall,
    input sbsm_pkg::out_beat_t out_item,
    input wire                 pready
);
    import sbsm_pkg::*;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("result beat changed under stall");

    // data byte only travels with a store
    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.write_enable |-> out_item.out_data == 8'd0)
        else $error("data byte without store");

    // stores go only to writable memories
    a_we_target: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.write_enable |->
            out_item.target == TGT_IRAM || out_item.target == TGT_CHR_RAM ||
            out_item.target == TGT_PRG_RAM)
        else $error("store to read-only or absent target");

    // no target means a zero offset and no store
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.target == TGT_NONE |->
            out_item.offset == 18'd0 && !out_item.write_enable)
        else $error("empty target with offset or store");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind serial_bank_switch_mapper sbsm_checker u_sbsm_checker (.*);

`default_nettype wire
